// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication checked in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wfa_pkg.sv =====
// ---------------------------------------------------------------------------
// wfa_pkg
// Types and codes shared by the worst-fit allocator modules.
// ---------------------------------------------------------------------------
package wfa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic CFG_HEAP_LIMIT = 1'b0;
  localparam logic CFG_MIN_SPLIT  = 1'b1;

  localparam logic [20:0] HEAP_LIMIT_RST = 21'd1048576;
  localparam logic [10:0] MIN_SPLIT_RST  = 11'd16;

  typedef struct packed {
    logic        op;
    logic [20:0] req_size;
    logic [19:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [19:0] addr;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        idx;
    logic [20:0] data;
  } cfg_beat_t;

endpackage

// ===== hdl/wfa_ram.sv =====
// ---------------------------------------------------------------------------
// wfa_ram
// Single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
module wfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/worst_fit_block_allocator_top.sv =====
// ---------------------------------------------------------------------------
// worst_fit_block_allocator_top
// Worst-fit allocator over an address-ordered block table held in RAM.
// ---------------------------------------------------------------------------
// channel | signals                         | beat moves when
// in      | in_valid, in_stall, in_data     | in_valid & !in_stall
// out     | out_valid, out_stall, out_data  | out_valid & !out_stall
// cfg     | cfg_valid, cfg_ready, cfg_data  | cfg_valid & cfg_ready
// An allocate scans the table once, one entry per cycle. A split then
// moves each entry above the pick up one place (read, then write).
// A free scans the whole table, then compacts it in one read/write pass,
// one entry per cycle. Zero-size allocates and frees of address zero skip
// the table and go straight to the result.
// Synchronous reset clears count, heap top and the control flags and restores the config defaults; no table sweep.
// The result waits in an output register while out_stall is high.
module worst_fit_block_allocator_top #(
  parameter int MAX_BLOCKS      = 64,
  parameter int HEADER_BYTES    = 32,
  parameter int ARENA_ADDR_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  wfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wfa_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  wfa_pkg::cfg_beat_t cfg_data
);
  import wfa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = 33;          // sizes and addresses, wide enough for sums
  localparam int EW = 2 * SW + 1;  // table entry: start, size, free
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] ARENA = SW'(1) << ARENA_ADDR_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SHW   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_MERGE = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_PICKR = 4'd8;

  logic [3:0]    state;
  logic [20:0]   heap_limit;
  logic [10:0]   min_split;
  logic [CW-1:0] count;
  logic [SW-1:0] heap_top;
  logic          op;
  logic [SW-1:0] need;
  logic [SW-1:0] faddr;
  logic [CW-1:0] ri;        // read index issued
  logic          rd_pend;   // rdata holds entry rd_idx
  logic [CW-1:0] rd_idx;
  logic          found;
  logic [IW-1:0] pick;
  logic [SW-1:0] pick_size;
  logic [SW-1:0] pick_start;
  logic [CW-1:0] wi;        // write pointer for compaction / shift
  logic          acc_v;     // merge accumulator holds an entry
  logic [SW-1:0] acc_start;
  logic [SW-1:0] acc_size;
  logic          acc_free;
  logic [19:0]   res_addr;
  logic [1:0]    res_status;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic [SW-1:0] r_start;
  logic [SW-1:0] r_size;
  logic          r_free;
  logic [SW-1:0] cap;
  logic [SW-1:0] grow_end;

  assign r_start = rdata[EW-1 -: SW];
  assign r_size  = rdata[SW:1];
  assign r_free  = rdata[0];
  assign cap = (SW'(heap_limit) < ARENA) ? SW'(heap_limit) : ARENA;
  assign grow_end = heap_top + HDR + need;

  wfa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{addr: res_addr, status: res_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= HEAP_LIMIT_RST;
      min_split  <= MIN_SPLIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data.idx == CFG_HEAP_LIMIT) begin
        heap_limit <= cfg_data.data;
      end else begin
        min_split <= cfg_data.data[10:0];
      end
    end
  end

  // Memory port control is combinational from state
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = ri[IW-1:0];
    case (state)
      S_DEC: begin
        if (op == OP_ALLOC && !found && count < CW'(MAX_BLOCKS)
            && grow_end <= cap) begin
          we    = 1'b1;
          waddr = count[IW-1:0];
          wdata = {heap_top, need, 1'b0};
        end
      end
      S_SHW: begin
        // write shifted entry rd_idx up one place
        we    = 1'b1;
        waddr = IW'(rd_idx + CW'(1));
        wdata = rdata;
      end
      S_FIN: begin
        we    = 1'b1;
        waddr = IW'(wi);
        wdata = {pick_start + HDR + need, pick_size - need - HDR, 1'b1};
      end
      S_MERGE: begin
        if (rd_pend && acc_v
            && !(acc_free && (r_free || rd_idx[IW-1:0] == pick))) begin
          we    = 1'b1;
          waddr = IW'(wi);
          wdata = {acc_start, acc_size, acc_free};
        end else if (!rd_pend && acc_v) begin
          we    = 1'b1;
          waddr = IW'(wi);
          wdata = {acc_start, acc_size, acc_free};
        end
      end
      S_PICKR: begin
        we    = 1'b1;
        waddr = pick;
        wdata = {pick_start, need, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      heap_top <= '0;
      rd_pend  <= 1'b0;
      acc_v    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= in_data.op;
            need      <= (SW'(in_data.req_size) + SW'(7)) & ~SW'(7);
            faddr     <= SW'(in_data.free_addr);
            ri        <= '0;
            rd_pend   <= 1'b0;
            found     <= 1'b0;
            res_addr  <= '0;
            acc_v     <= 1'b0;
            wi        <= '0;
            if (in_data.op == OP_ALLOC && in_data.req_size == '0) begin
              res_status <= ST_ZERO;
              state      <= S_OUT;
            end else if (in_data.op == OP_FREE && in_data.free_addr == '0) begin
              res_status <= ST_OK;
              state      <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue reads one a cycle, evaluate the returning entry
          if (ri < count) begin
            ri      <= ri + CW'(1);
            rd_pend <= 1'b1;
            rd_idx  <= ri;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (op == OP_ALLOC) begin
              if (r_free && r_size >= need && (!found || r_size > pick_size)) begin
                found      <= 1'b1;
                pick       <= rd_idx[IW-1:0];
                pick_size  <= r_size;
                pick_start <= r_start;
              end
            end else if (r_start + HDR == faddr && !found) begin
              found      <= 1'b1;
              pick       <= rd_idx[IW-1:0];
              pick_size  <= r_size;
              pick_start <= r_start;
              acc_free   <= r_free;
            end
          end
          if (ri >= count && (!rd_pend || ri == count) && !(ri < count)) begin
            if (!rd_pend || rd_idx + CW'(1) == count) begin
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          if (op == OP_ALLOC) begin
            if (found) begin
              res_status <= ST_OK;
              res_addr   <= 20'(pick_start + HDR);
              if (pick_size > need + HDR + SW'(min_split)
                  && count < CW'(MAX_BLOCKS)) begin
                // shift entries above pick up one, from the top down
                ri      <= count - CW'(1);
                rd_pend <= 1'b0;
                wi      <= CW'(pick) + CW'(1);
                state   <= S_SHIFT;
              end else begin
                need  <= pick_size;
                state <= S_PICKR;
              end
            end else if (count >= CW'(MAX_BLOCKS) || grow_end > cap) begin
              res_status <= ST_NOMEM;
              state      <= S_OUT;
            end else begin
              res_status <= ST_OK;
              res_addr   <= 20'(heap_top + HDR);
              count      <= count + CW'(1);
              heap_top   <= grow_end;
              state      <= S_OUT;
            end
          end else if (!found || acc_free) begin
            res_status <= ST_BADFREE;
            state      <= S_OUT;
          end else begin
            res_status <= ST_OK;
            ri         <= '0;
            wi         <= '0;
            rd_pend    <= 1'b0;
            acc_v      <= 1'b0;
            state      <= S_MERGE;
          end
        end
        S_SHIFT: begin
          // ri points at the next entry to move; stop below wi
          if (ri >= wi && ri != '1) begin
            rd_idx <= ri;
            state  <= S_SHW;
          end else begin
            state <= S_FIN;
          end
        end
        S_SHW: begin
          if (ri == wi) begin
            state <= S_FIN;
          end else begin
            ri    <= ri - CW'(1);
            state <= S_SHIFT;
          end
        end
        S_FIN: begin
          count <= count + CW'(1);
          state <= S_PICKR;
        end
        S_PICKR: begin
          state <= S_OUT;
        end
        S_MERGE: begin
          // stream entries through an accumulator, merging free runs
          if (ri < count) begin
            ri      <= ri + CW'(1);
            rd_pend <= 1'b1;
            rd_idx  <= ri;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (!acc_v) begin
              acc_v     <= 1'b1;
              acc_start <= r_start;
              acc_size  <= r_size;
              acc_free  <= r_free || (rd_idx[IW-1:0] == pick);
            end else if (acc_free && (r_free || rd_idx[IW-1:0] == pick)) begin
              acc_size <= acc_size + HDR + r_size;
            end else begin
              wi        <= wi + CW'(1);
              acc_start <= r_start;
              acc_size  <= r_size;
              acc_free  <= r_free || (rd_idx[IW-1:0] == pick);
            end
          end else if (ri >= count && acc_v) begin
            count <= wi + CW'(1);
            acc_v <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/wfa_checker.sv =====
// ---------------------------------------------------------------------------
// wfa_checker
// Port-level checks on the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module wfa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input wfa_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input wfa_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input wfa_pkg::cfg_beat_t cfg_data
);
  import wfa_pkg::*;

  `CHK_IMPLY(a_fail_no_addr, clk, rst, out_valid && out_data.status != ST_OK, out_data.addr == '0, "failed beat carries an address")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `CHK_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall, "second item taken while busy")
  `CHK_IMPLY(a_cfg_idle, clk, rst, cfg_ready, !out_valid, "config taken while result pending")
endmodule

bind worst_fit_block_allocator_top wfa_checker u_wfa_checker (.*);
